[hdl/bscu_pkg.sv]
// Shared widths, register indexes and temperature constants for the compensation unit.
package bscu_pkg;

  // Port field widths
  localparam int unsigned RawW    = 24;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned TempW   = 15;
  localparam int unsigned PresW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumCoef = 6;

  // Corrected sensitivity and offset, and the full pressure product
  localparam int unsigned SensW = 37;
  localparam int unsigned OffW  = 38;
  localparam int unsigned ProdW = RawW + SensW + 1;

  // Split point of the sensitivity word for the two partial products
  localparam int unsigned SplitW = 18;

  // Calibration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_SENS  = 3'd0,
    CFG_PRESS_OFF   = 3'd1,
    CFG_SENS_TCO    = 3'd2,
    CFG_OFF_TCO     = 3'd3,
    CFG_TEMP_REF    = 3'd4,
    CFG_TEMP_SLOPE  = 3'd5
  } cfg_idx_e;

  // Temperature thresholds in centidegrees, relative where noted
  localparam logic signed [19:0] TempRef       = 20'sd2000;
  localparam logic signed [19:0] VlowOfs       = 20'sd3500;  // -1500 absolute (-3500 relative to reference)
  localparam logic signed [18:0] DeltaMin      = -19'sd7000; // -5000 absolute
  localparam logic signed [18:0] DeltaMax      = 19'sd8000;  // 10000 absolute
  localparam logic signed [19:0] TempFieldMin  = -20'sd16384;

endpackage

[hdl/bscu_press_mul.sv]
// Two-stage signed multiplier: raw pressure times corrected sensitivity.
module bscu_press_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [bscu_pkg::RawW-1:0]            d1_i,
  input  logic signed [bscu_pkg::SensW-1:0]    sens_i,
  output logic                                 valid_o,
  output logic signed [bscu_pkg::ProdW-1:0]    prod_o
);

  localparam int unsigned LoW = bscu_pkg::RawW + bscu_pkg::SplitW;
  localparam int unsigned HiW = bscu_pkg::RawW + 1 + bscu_pkg::SensW - bscu_pkg::SplitW;

  logic                     va_q;
  logic [LoW-1:0]           lo_d, lo_q;
  logic signed [HiW-1:0]    hi_d, hi_q;
  logic signed [bscu_pkg::ProdW-1:0] prod_d, prod_q;
  logic                     vb_q;

  // Form partial products on the low and high halves of the sensitivity
  assign lo_d = LoW'(d1_i) * LoW'(sens_i[bscu_pkg::SplitW-1:0]);
  assign hi_d = HiW'($signed({1'b0, d1_i})) *
                HiW'($signed(sens_i[bscu_pkg::SensW-1:bscu_pkg::SplitW]));

  // Recombine the halves
  assign prod_d = $signed({hi_q, {bscu_pkg::SplitW{1'b0}}}) +
                  $signed({{(bscu_pkg::ProdW-LoW){1'b0}}, lo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    prod_q <= prod_d;
  end

  assign valid_o = vb_q;
  assign prod_o  = prod_q;

endmodule

[hdl/baro_sensor_compensation_unit.sv]
// Top level of the barometric second-order compensation pipeline.
// Throughput: one word per cycle; busy stays low, so start may be held high.
// Depth is set by the nine-register chain: deltas, products, first order,
// squares, second order, correction, two multiplier stages, output.
// Reset clears the valid chain and the six calibration registers to zero.
// The receiver cannot stall; each result shows for exactly one cycle.
module baro_sensor_compensation_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // calibration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bscu_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [bscu_pkg::CoefW-1:0]            cfg_data_i,
  // command side
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bscu_pkg::RawW-1:0]             raw_pressure_sample_i,
  input  logic [bscu_pkg::RawW-1:0]             raw_temperature_sample_i,
  // result side
  output logic                                  out_valid_o,
  output logic signed [bscu_pkg::TempW-1:0]     temperature_centideg_o,
  output logic signed [bscu_pkg::PresW-1:0]     pressure_centimbar_o,
  output logic                                  result_valid_o
);

  logic [bscu_pkg::CoefW-1:0] coef_q [bscu_pkg::NumCoef];

  // Valid chain for the stages kept in this module
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_v_q;

  // Stage 1: temperature delta
  logic [bscu_pkg::RawW-1:0] s1_d1_q;
  logic signed [24:0]        dt_d, s1_dt_q;

  // Stage 2: products
  logic [bscu_pkg::RawW-1:0] s2_d1_q;
  logic signed [41:0]        s2_dtc6_q, s2_c4dt_q, s2_c3dt_q;
  logic signed [49:0]        dtsq_full;
  logic [48:0]               s2_dtsq_q;

  // Stage 3: first order
  logic [bscu_pkg::RawW-1:0] s3_d1_q;
  logic signed [18:0]        s3_a_q;
  logic signed [36:0]        off_d, s3_off_q;
  logic signed [35:0]        sens_d, s3_sens_q;
  logic [50:0]               dtsq5;
  logic [49:0]               dtsq3;
  logic [12:0]               s3_t2h_q;
  logic [16:0]               s3_t2l_q;

  // Stage 4: squares, range and corrected temperature
  logic [bscu_pkg::RawW-1:0] s4_d1_q;
  logic signed [36:0]        s4_off_q;
  logic signed [35:0]        s4_sens_q;
  logic signed [37:0]        asq_full;
  logic signed [19:0]        b_d;
  logic signed [39:0]        bsq_full;
  logic [25:0]               s4_asq_q;
  logic [23:0]               s4_bsq_q;
  logic                      lt_ref_d, lt_vlow_d, in_rng_d;
  logic                      s4_lt_ref_q, s4_lt_vlow_q, s4_in_rng_q;
  logic signed [19:0]        temp_d, t_full_d;
  logic [16:0]               t2_sel_d;
  logic signed [bscu_pkg::TempW-1:0] t_d, s4_t_q;

  // Stage 5: second order terms
  logic [bscu_pkg::RawW-1:0] s5_d1_q;
  logic signed [36:0]        s5_off_q;
  logic signed [35:0]        s5_sens_q;
  logic [31:0]               p61;
  logic [28:0]               q17;
  logic [30:0]               p29;
  logic [27:0]               q9;
  logic [29:0]               off2_d, s5_off2_q;
  logic [28:0]               sens2_d, s5_sens2_q;
  logic                      s5_in_rng_q;
  logic signed [bscu_pkg::TempW-1:0] s5_t_q;

  // Stage 6: corrected offset and sensitivity
  logic [bscu_pkg::RawW-1:0]             s6_d1_q;
  logic signed [bscu_pkg::OffW-1:0]      offc_d, s6_offc_q;
  logic signed [bscu_pkg::SensW-1:0]     sensc_d, s6_sensc_q;
  logic                                  s6_in_rng_q;
  logic signed [bscu_pkg::TempW-1:0]     s6_t_q;

  // Stages 7 and 8: side data beside the multiplier
  logic signed [bscu_pkg::OffW-1:0]      s7_offc_q, s8_offc_q;
  logic                                  s7_in_rng_q, s8_in_rng_q;
  logic signed [bscu_pkg::TempW-1:0]     s7_t_q, s8_t_q;
  logic                                  mul_v;
  logic signed [bscu_pkg::ProdW-1:0]     prod;

  // Stage 9: final pressure
  logic signed [41:0]                    q_d;
  logic signed [bscu_pkg::PresW-1:0]     p_d;
  logic signed [bscu_pkg::TempW-1:0]     out_t_q;
  logic signed [bscu_pkg::PresW-1:0]     out_p_q;
  logic                                  out_rv_q;

  logic accept;

  // Accept a word every cycle
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Write calibration registers; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bscu_pkg::cfg_idx_e'(cfg_index_i))
        bscu_pkg::CFG_PRESS_SENS: coef_q[bscu_pkg::CFG_PRESS_SENS] <= cfg_data_i;
        bscu_pkg::CFG_PRESS_OFF:  coef_q[bscu_pkg::CFG_PRESS_OFF]  <= cfg_data_i;
        bscu_pkg::CFG_SENS_TCO:   coef_q[bscu_pkg::CFG_SENS_TCO]   <= cfg_data_i;
        bscu_pkg::CFG_OFF_TCO:    coef_q[bscu_pkg::CFG_OFF_TCO]    <= cfg_data_i;
        bscu_pkg::CFG_TEMP_REF:   coef_q[bscu_pkg::CFG_TEMP_REF]   <= cfg_data_i;
        bscu_pkg::CFG_TEMP_SLOPE: coef_q[bscu_pkg::CFG_TEMP_SLOPE] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      out_v_q <= mul_v;
    end
  end

  // Stage 1: delta between raw temperature and reference
  assign dt_d = $signed({1'b0, raw_temperature_sample_i}) -
                $signed({1'b0, coef_q[bscu_pkg::CFG_TEMP_REF], 8'h00});

  // Stage 2: delta products
  assign dtsq_full = 50'(s1_dt_q) * 50'(s1_dt_q);

  // Stage 3: first-order temperature delta, offset, sensitivity and both T2 forms
  assign off_d  = $signed({4'b0, coef_q[bscu_pkg::CFG_PRESS_OFF], 17'b0}) +
                  $signed({s2_c4dt_q[41], s2_c4dt_q[41:6]});
  assign sens_d = $signed({4'b0, coef_q[bscu_pkg::CFG_PRESS_SENS], 16'b0}) +
                  $signed({s2_c3dt_q[41], s2_c3dt_q[41:7]});
  assign dtsq5  = {s2_dtsq_q, 2'b00} + {2'b00, s2_dtsq_q};
  assign dtsq3  = {s2_dtsq_q, 1'b0} + {1'b0, s2_dtsq_q};

  // Stage 4: squares of the two deltas, range check, corrected temperature
  assign asq_full  = 38'(s3_a_q) * 38'(s3_a_q);
  assign b_d       = $signed({s3_a_q[18], s3_a_q}) + bscu_pkg::VlowOfs;
  assign bsq_full  = 40'(b_d) * 40'(b_d);
  assign lt_ref_d  = s3_a_q[18];
  assign lt_vlow_d = b_d[19];
  assign in_rng_d  = (s3_a_q >= bscu_pkg::DeltaMin) && (s3_a_q <= bscu_pkg::DeltaMax);
  assign temp_d    = $signed({s3_a_q[18], s3_a_q}) + bscu_pkg::TempRef;
  assign t2_sel_d  = lt_ref_d ? s3_t2l_q : {4'b0, s3_t2h_q};
  assign t_full_d  = temp_d - $signed({3'b0, t2_sel_d});

  // Clamp the corrected temperature at the bottom of the field
  always_comb begin
    if (t_full_d < bscu_pkg::TempFieldMin) begin
      t_d = bscu_pkg::TempW'(bscu_pkg::TempFieldMin);
    end else begin
      t_d = t_full_d[bscu_pkg::TempW-1:0];
    end
  end

  // Stage 5: offset and sensitivity corrections for low and very low temperature
  assign p61 = {6'b0, s4_asq_q} * 32'd61;
  assign q17 = {5'b0, s4_bsq_q} * 29'd17;
  assign p29 = {5'b0, s4_asq_q} * 31'd29;
  assign q9  = {4'b0, s4_bsq_q} * 28'd9;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (s4_lt_ref_q) begin
      off2_d  = {2'b0, p61[31:4]};
      sens2_d = {2'b0, p29[30:4]};
      if (s4_lt_vlow_q) begin
        off2_d  = off2_d + {1'b0, q17};
        sens2_d = sens2_d + {1'b0, q9};
      end
    end
  end

  // Stage 6: apply corrections
  assign offc_d  = $signed({s5_off_q[36], s5_off_q}) - $signed({8'b0, s5_off2_q});
  assign sensc_d = $signed({s5_sens_q[35], s5_sens_q}) - $signed({8'b0, s5_sens2_q});

  // Stages 7 and 8: pressure product
  bscu_press_mul u_press_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .d1_i    (s6_d1_q),
    .sens_i  (s6_sensc_q),
    .valid_o (mul_v),
    .prod_o  (prod)
  );

  // Stage 9: scale, subtract offset, scale again; the result always fits 32 bits
  assign q_d = $signed({prod[bscu_pkg::ProdW-1], prod[bscu_pkg::ProdW-1:21]}) -
               $signed({{4{s8_offc_q[bscu_pkg::OffW-1]}}, s8_offc_q});
  assign p_d = $signed({{5{q_d[41]}}, q_d[41:15]});

  // Hold the datapath registers; they have no reset, only the valid chain is reset
  always_ff @(posedge clk_i) begin
    s1_d1_q      <= raw_pressure_sample_i;
    s1_dt_q      <= dt_d;

    s2_d1_q      <= s1_d1_q;
    s2_dtc6_q    <= 42'(s1_dt_q) * $signed(42'(coef_q[bscu_pkg::CFG_TEMP_SLOPE]));
    s2_c4dt_q    <= 42'(s1_dt_q) * $signed(42'(coef_q[bscu_pkg::CFG_OFF_TCO]));
    s2_c3dt_q    <= 42'(s1_dt_q) * $signed(42'(coef_q[bscu_pkg::CFG_SENS_TCO]));
    s2_dtsq_q    <= dtsq_full[48:0];

    s3_d1_q      <= s2_d1_q;
    s3_a_q       <= s2_dtc6_q[41:23];
    s3_off_q     <= off_d;
    s3_sens_q    <= sens_d;
    s3_t2h_q     <= dtsq5[50:38];
    s3_t2l_q     <= dtsq3[49:33];

    s4_d1_q      <= s3_d1_q;
    s4_off_q     <= s3_off_q;
    s4_sens_q    <= s3_sens_q;
    s4_asq_q     <= asq_full[25:0];
    s4_bsq_q     <= bsq_full[23:0];
    s4_lt_ref_q  <= lt_ref_d;
    s4_lt_vlow_q <= lt_vlow_d;
    s4_in_rng_q  <= in_rng_d;
    s4_t_q       <= t_d;

    s5_d1_q      <= s4_d1_q;
    s5_off_q     <= s4_off_q;
    s5_sens_q    <= s4_sens_q;
    s5_off2_q    <= off2_d;
    s5_sens2_q   <= sens2_d;
    s5_in_rng_q  <= s4_in_rng_q;
    s5_t_q       <= s4_t_q;

    s6_d1_q      <= s5_d1_q;
    s6_offc_q    <= offc_d;
    s6_sensc_q   <= sensc_d;
    s6_in_rng_q  <= s5_in_rng_q;
    s6_t_q       <= s5_t_q;

    s7_offc_q    <= s6_offc_q;
    s7_in_rng_q  <= s6_in_rng_q;
    s7_t_q       <= s6_t_q;

    s8_offc_q    <= s7_offc_q;
    s8_in_rng_q  <= s7_in_rng_q;
    s8_t_q       <= s7_t_q;

    // Zero the word when the first-order temperature is out of range
    out_rv_q     <= s8_in_rng_q;
    out_t_q      <= s8_in_rng_q ? s8_t_q : '0;
    out_p_q      <= s8_in_rng_q ? p_d : '0;
  end

  assign out_valid_o            = out_v_q;
  assign temperature_centideg_o = out_t_q;
  assign pressure_centimbar_o   = out_p_q;
  assign result_valid_o         = out_rv_q;

endmodule

[hdl/bscu_checker.sv]
// Port-level checks on the compensation unit and their bind to the top level.
module bscu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid_o,
  input logic                               result_valid_o,
  input logic signed [bscu_pkg::TempW-1:0]  temperature_centideg_o,
  input logic signed [bscu_pkg::PresW-1:0]  pressure_centimbar_o
);

  // Every accepted word yields a result at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##9 out_valid_o)
    else $error("result missing nine cycles after accept");

  // No result appears without a matching accept
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy && rst_ni, 9))
    else $error("result without accepted word");

  // Out-of-range results carry zero values
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_valid_o) |->
      (temperature_centideg_o == '0) && (pressure_centimbar_o == '0))
    else $error("invalid result carries nonzero values");

  // Valid temperatures stay at or below the upper range limit
  a_temp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_valid_o) |-> (temperature_centideg_o <= 15'sd10000))
    else $error("temperature above range on a valid result");

endmodule

bind baro_sensor_compensation_unit bscu_checker u_bscu_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .start                  (start),
  .busy                   (busy),
  .out_valid_o            (out_valid_o),
  .result_valid_o         (result_valid_o),
  .temperature_centideg_o (temperature_centideg_o),
  .pressure_centimbar_o   (pressure_centimbar_o)
);

[bench/baro_sensor_compensation_unit_tb.sv]
// Self-checking testbench for the barometric second-order compensation unit.
module baro_sensor_compensation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Temperature thresholds in centidegrees and pressure saturation bounds
  localparam longint TempRefC   = 2000;
  localparam longint TempVlowC  = -1500;
  localparam longint TempMinC   = -5000;
  localparam longint TempMaxC   = 10000;
  localparam longint TempFloorC = -16384;
  localparam longint PresMaxC   = (longint'(1) <<< 31) - 1;
  localparam longint PresMinC   = -(longint'(1) <<< 31);

  localparam realtime HalfPeriod  = 4ns;
  localparam int      PipeLatency = 9;
  localparam int      CycleLimit  = 200000;
  localparam int      MaxPrinted  = 200;
  localparam int      ItemsPerSet = 190;

  localparam logic [bscu_pkg::RawW-1:0] RawMax = '1;

  typedef struct packed {
    logic signed [bscu_pkg::TempW-1:0] temp;
    logic signed [bscu_pkg::PresW-1:0] pres;
    logic                              ok;
  } reading_t;

  typedef logic [bscu_pkg::NumCoef-1:0][bscu_pkg::CoefW-1:0] calib_t;

  // Six calibration words, lowest slice is the pressure sensitivity
  localparam calib_t TypicalCal = {16'd28312, 16'd33464, 16'd23282,
                                   16'd23317, 16'd36924, 16'd40127};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [bscu_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [bscu_pkg::CoefW-1:0]         cfg_data_i;
  logic                               start;
  logic                               busy;
  logic [bscu_pkg::RawW-1:0]          raw_pressure_sample_i;
  logic [bscu_pkg::RawW-1:0]          raw_temperature_sample_i;
  logic                               out_valid_o;
  logic signed [bscu_pkg::TempW-1:0]  temperature_centideg_o;
  logic signed [bscu_pkg::PresW-1:0]  pressure_centimbar_o;
  logic                               result_valid_o;

  // Calibration copy and the readings still owed by the pipeline
  logic [bscu_pkg::CoefW-1:0] cal [bscu_pkg::NumCoef];
  reading_t                   reading_q [$];
  int unsigned                mismatch_count = 0;
  int unsigned                cycle_count = 0;

  baro_sensor_compensation_unit i_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .start                    (start),
    .busy                     (busy),
    .raw_pressure_sample_i    (raw_pressure_sample_i),
    .raw_temperature_sample_i (raw_temperature_sample_i),
    .out_valid_o              (out_valid_o),
    .temperature_centideg_o   (temperature_centideg_o),
    .pressure_centimbar_o     (pressure_centimbar_o),
    .result_valid_o           (result_valid_o)
  );

  // Toggle the clock
  always #(HalfPeriod) clk_i = ~clk_i;

  // Compute the compensated reading for one sample pair
  function automatic reading_t compensate(input logic [bscu_pkg::RawW-1:0] d1_raw,
                                          input logic [bscu_pkg::RawW-1:0] d2_raw);
    longint   d1, dt, temp, off, sens, t2, off2, sens2, sq, t, p;
    reading_t r;
    d1   = longint'(d1_raw);
    dt   = longint'(d2_raw) - longint'(cal[bscu_pkg::CFG_TEMP_REF]) * 256;
    temp = TempRefC + ((dt * longint'(cal[bscu_pkg::CFG_TEMP_SLOPE])) >>> 23);
    off  = longint'(cal[bscu_pkg::CFG_PRESS_OFF]) * 131072
         + ((longint'(cal[bscu_pkg::CFG_OFF_TCO]) * dt) >>> 6);
    sens = longint'(cal[bscu_pkg::CFG_PRESS_SENS]) * 65536
         + ((longint'(cal[bscu_pkg::CFG_SENS_TCO]) * dt) >>> 7);
    r = '0;
    // Out-of-range first-order temperature gives an all-zero word
    if (temp < TempMinC || temp > TempMaxC) return r;
    if (temp >= TempRefC) begin
      t2    = (5 * dt * dt) >>> 38;
      off2  = 0;
      sens2 = 0;
    end else begin
      t2    = (3 * dt * dt) >>> 33;
      sq    = (temp - TempRefC) * (temp - TempRefC);
      off2  = (61 * sq) >>> 4;
      sens2 = (29 * sq) >>> 4;
      // Add the very-low-temperature terms
      if (temp < TempVlowC) begin
        sq    = (temp - TempVlowC) * (temp - TempVlowC);
        off2  = off2 + 17 * sq;
        sens2 = sens2 + 9 * sq;
      end
    end
    t = temp - t2;
    if (t < TempFloorC) t = TempFloorC;
    p = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
    if (p > PresMaxC) p = PresMaxC;
    if (p < PresMinC) p = PresMinC;
    r.temp = t[bscu_pkg::TempW-1:0];
    r.pres = p[bscu_pkg::PresW-1:0];
    r.ok   = 1'b1;
    return r;
  endfunction

  // Pick a raw temperature whose first-order temperature hits the target
  function automatic logic [bscu_pkg::RawW-1:0] raw_temp_for(input longint target);
    longint slope, num, dt, d2;
    slope = longint'(cal[bscu_pkg::CFG_TEMP_SLOPE]);
    if (slope == 0) return bscu_pkg::RawW'($urandom);
    num = (target - TempRefC) * (longint'(1) <<< 23);
    // Round the delta up so the floor lands exactly on the target
    dt = num / slope;
    if (num > 0 && num % slope != 0) dt = dt + 1;
    d2 = dt + longint'(cal[bscu_pkg::CFG_TEMP_REF]) * 256;
    if (d2 < 0) d2 = 0;
    if (d2 > longint'(RawMax)) d2 = longint'(RawMax);
    return d2[bscu_pkg::RawW-1:0];
  endfunction

  // Favor the region boundaries, otherwise spread over and just past the valid band
  function automatic longint random_target();
    longint jitter;
    jitter = longint'($urandom_range(6)) - 3;
    case ($urandom_range(9))
      0:       return TempMinC + jitter;
      1:       return TempVlowC + jitter;
      2:       return TempRefC + jitter;
      3:       return TempMaxC + jitter;
      default: return TempMinC - 300 + longint'($urandom_range(15600));
    endcase
  endfunction

  function automatic logic [bscu_pkg::RawW-1:0] random_raw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RawMax;
      default: return bscu_pkg::RawW'($urandom);
    endcase
  endfunction

  function automatic calib_t random_calib();
    calib_t v;
    for (int i = 0; i < bscu_pkg::NumCoef; i++) begin
      case ($urandom_range(9))
        0:       v[i] = '0;
        1:       v[i] = '1;
        default: v[i] = bscu_pkg::CoefW'($urandom);
      endcase
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Write one calibration register; unknown indexes leave the copy untouched
  task automatic write_register(input logic [bscu_pkg::CfgIdxW-1:0] idx,
                                input logic [bscu_pkg::CoefW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < bscu_pkg::NumCoef) cal[idx] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_calibration(input calib_t v);
    for (int i = 0; i < bscu_pkg::NumCoef; i++)
      write_register(bscu_pkg::CfgIdxW'(i), v[i]);
  endtask

  task automatic poke_unknown_registers();
    for (int i = bscu_pkg::NumCoef; i < (1 << bscu_pkg::CfgIdxW); i++)
      write_register(bscu_pkg::CfgIdxW'(i), bscu_pkg::CoefW'($urandom));
  endtask

  // Send one sample pair and record the reading it must produce
  task automatic send_sample(input logic [bscu_pkg::RawW-1:0] d1,
                             input logic [bscu_pkg::RawW-1:0] d2);
    @(negedge clk_i);
    start                    = 1'b1;
    raw_pressure_sample_i    = d1;
    raw_temperature_sample_i = d2;
    do @(posedge clk_i); while (busy);
    reading_q.push_back(compensate(d1, d2));
  endtask

  // Hold start low with junk on the sample ports
  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start                    = 1'b0;
      raw_pressure_sample_i    = bscu_pkg::RawW'($urandom);
      raw_temperature_sample_i = bscu_pkg::RawW'($urandom);
    end
  endtask

  // Drop start and wait for every owed reading
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
  endtask

  // Reset calibration is all zero, then load a known set plus stray writes
  task automatic test_register_map();
    send_sample(RawMax, RawMax);
    send_sample(24'd123456, '0);
    drain();
    load_calibration(TypicalCal);
    poke_unknown_registers();
  endtask

  // Walk the temperature regions and their edges with the known set
  task automatic test_region_edges();
    send_sample('0, raw_temp_for(TempRefC));
    send_sample(RawMax, raw_temp_for(TempRefC));
    send_sample(random_raw(), raw_temp_for(TempRefC - 1));
    send_sample(RawMax, raw_temp_for(TempVlowC));
    send_sample(RawMax, raw_temp_for(TempVlowC - 1));
    send_sample(random_raw(), raw_temp_for(TempMinC));
    send_sample(random_raw(), raw_temp_for(TempMinC - 1));
    send_sample(random_raw(), raw_temp_for(TempMaxC));
    send_sample(random_raw(), raw_temp_for(TempMaxC + 1));
    send_sample(random_raw(), '0);
    send_sample(random_raw(), RawMax);
    send_sample(RawMax, raw_temp_for(5000));
    send_sample('0, raw_temp_for(-3000));
    send_sample(random_raw(), raw_temp_for(8000));
    drain();
  endtask

  // Large negative delta with a shallow slope drives the correction past the floor
  task automatic test_temperature_floor();
    calib_t v;
    v                           = TypicalCal;
    v[bscu_pkg::CFG_TEMP_REF]   = '1;
    v[bscu_pkg::CFG_TEMP_SLOPE] = 16'd1000;
    load_calibration(v);
    send_sample(RawMax, '0);
    send_sample('0, '0);
    drain();
  endtask

  // All-zero and all-ones calibration
  task automatic test_calibration_extremes();
    load_calibration('0);
    send_sample(RawMax, '0);
    send_sample(RawMax, RawMax);
    send_sample('0, RawMax);
    drain();
    load_calibration('1);
    send_sample(RawMax, RawMax);
    send_sample(RawMax, '0);
    send_sample(RawMax, raw_temp_for(TempRefC));
    drain();
  endtask

  // Random sample pairs under random calibration, three sender idle rates
  task automatic test_random_traffic();
    int unsigned               idle_pct [3] = '{10, 55, 0};
    logic [bscu_pkg::RawW-1:0] d2;
    for (int phase = 0; phase < 3; phase++) begin
      for (int set = 0; set < 3; set++) begin
        drain();
        load_calibration(random_calib());
        if ($urandom_range(1)) poke_unknown_registers();
        for (int n = 0; n < ItemsPerSet; n++) begin
          // Idle each cycle with the phase's probability
          while ($urandom_range(99) < idle_pct[phase]) idle_sender(1);
          if ($urandom_range(99) < 75) d2 = raw_temp_for(random_target());
          else d2 = bscu_pkg::RawW'($urandom);
          send_sample(random_raw(), d2);
        end
      end
    end
    drain();
  endtask

  // Compare each result word with the oldest owed reading
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_valid_o) begin
      if (reading_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word temp %0d pres %0d valid %0b",
                                  temperature_centideg_o, pressure_centimbar_o,
                                  result_valid_o));
      end else begin
        want = reading_q.pop_front();
        if (temperature_centideg_o !== want.temp)
          report_mismatch($sformatf("temperature got %0d want %0d",
                                    temperature_centideg_o, want.temp));
        if (pressure_centimbar_o !== want.pres)
          report_mismatch($sformatf("pressure got %0d want %0d",
                                    pressure_centimbar_o, want.pres));
        if (result_valid_o !== want.ok)
          report_mismatch($sformatf("valid flag got %0b want %0b",
                                    result_valid_o, want.ok));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("baro_sensor_compensation_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    clk_i                    = 1'b0;
    rst_ni                   = 1'b0;
    cfg_valid_i              = 1'b0;
    cfg_index_i              = '0;
    cfg_data_i               = '0;
    start                    = 1'b0;
    raw_pressure_sample_i    = '0;
    raw_temperature_sample_i = '0;
    for (int i = 0; i < bscu_pkg::NumCoef; i++) cal[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_map();
    test_region_edges();
    test_temperature_floor();
    test_calibration_extremes();
    test_random_traffic();

    // Let any stray word surface before the verdict
    drain();
    repeat (2 * PipeLatency) @(posedge clk_i);
    if (mismatch_count == 0 && reading_q.size() == 0)
      $display("baro_sensor_compensation_unit_tb: PASS");
    else
      $display("baro_sensor_compensation_unit_tb: FAIL");
    $finish;
  end

endmodule

[baro_sensor_compensation_unit.f]
hdl/bscu_pkg.sv
hdl/bscu_press_mul.sv
hdl/baro_sensor_compensation_unit.sv
hdl/bscu_checker.sv
bench/baro_sensor_compensation_unit_tb.sv
